// ===== rtl/core/crc32fs_pkg.sv =====
// package: shared constants, transaction types and crc byte update for the frame sealer
`timescale 1ns / 1ps

package crc32fs_pkg;

    localparam int FRAME_BYTES = 60;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int CRC_W       = 32;
    localparam int CRC_BYTES   = CRC_W / 8;
    localparam int CRC_IDX_W   = $clog2(CRC_BYTES);

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       frame_overflow;
    } out_item_t;

    // reflected crc-32, one byte folded in lsb first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0]       b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-8){1'b0}}, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc32_frame_sealer.sv =====
// top level: crc-32 frame sealer with frame byte store and replay
`timescale 1ns / 1ps

// channel  | role   | signals                           | payload
// ---------+--------+-----------------------------------+----------------------------------
// byte     | sink   | byte_valid, byte_stall, byte_item | data_byte, last_byte
// seal     | source | seal_valid, seal_stall, seal_item | out_byte, out_last, frame_overflow
//
// loading: one byte transaction per cycle; each byte that fits goes into the frame store
//   (single-port synchronous ram, one write per cycle) and through the crc update
// sealing: after the last byte, four crc bytes from the crc register, then the replay
//   streams the store at one read per cycle while the seal side does not stall,
//   and byte_stall stays high until the last replayed byte is loaded
// reset clears the counters and overflow flag and presets the crc at once;
//   the store is not cleared since replay only reads entries written in the current frame
// a stall on the seal side holds the output register and freezes the store reads;
//   the next byte transaction is taken while the final result still waits

module crc32_frame_sealer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  crc32fs_pkg::in_item_t byte_item,
    output logic                  seal_valid,
    input  logic                  seal_stall,
    output crc32fs_pkg::out_item_t seal_item
);

    import crc32fs_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,   // taking frame bytes
        S_CRC,    // sending the four crc bytes
        S_SEND    // replaying the store, read data registered from the address
    } state_t;

    // frame store
    logic [7:0] frame_store [FRAME_BYTES];
    logic [7:0] rd_data_reg;

    state_t                 state_reg,      state_next;
    logic [CNT_W-1:0]       byte_count_reg, byte_count_next;
    logic [CRC_W-1:0]       crc_reg,        crc_next;
    logic                   ovf_reg,        ovf_next;
    logic [CRC_IDX_W-1:0]   crc_idx_reg,    crc_idx_next;
    logic [CNT_W-1:0]       rd_idx_reg,     rd_idx_next;
    logic                   out_valid_reg,  out_valid_next;
    out_item_t              out_item_reg,   out_item_next;

    logic             in_take;
    logic             wr_en;
    logic             rd_en;
    logic [CNT_W-1:0] rd_addr;
    logic             slot_free;
    logic [CRC_W-1:0] crc_out;
    logic             last_replay;

    assign byte_stall = (state_reg != S_LOAD);
    assign in_take    = byte_valid && !byte_stall;
    assign wr_en      = in_take && (byte_count_reg < CNT_W'(FRAME_BYTES));
    assign slot_free  = !out_valid_reg || !seal_stall;
    assign crc_out    = ~crc_reg;
    assign last_replay = (rd_idx_reg + CNT_W'(1)) == byte_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        ovf_next        = ovf_reg;
        crc_idx_next    = crc_idx_reg;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_idx_reg + CNT_W'(1);

        // result taken, slot empties unless refilled below
        if (out_valid_reg && !seal_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_take)
                begin
                    if (wr_en)
                    begin
                        byte_count_next = byte_count_reg + CNT_W'(1);
                        crc_next        = crc_byte(crc_reg, byte_item.data_byte);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (byte_item.last_byte)
                    begin
                        crc_idx_next = '0;
                        state_next   = S_CRC;
                    end
                end
            end
            S_CRC:
            begin
                if (slot_free)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.out_byte       = crc_out[crc_idx_reg*8 +: 8];
                    out_item_next.out_last       = 1'b0;
                    out_item_next.frame_overflow = ovf_reg;
                    crc_idx_next                 = crc_idx_reg + CRC_IDX_W'(1);
                    if (crc_idx_reg == CRC_IDX_W'(CRC_BYTES - 1))
                    begin
                        if (byte_count_reg != '0)
                        begin
                            // first store read overlaps the last crc byte
                            rd_en       = 1'b1;
                            rd_addr     = '0;
                            rd_idx_next = '0;
                            state_next  = S_SEND;
                        end
                        else
                        begin
                            byte_count_next = '0;
                            crc_next        = CRC_INIT;
                            ovf_next        = 1'b0;
                            state_next      = S_LOAD;
                        end
                    end
                end
            end
            S_SEND:
            begin
                if (slot_free)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.out_byte       = rd_data_reg;
                    out_item_next.out_last       = last_replay;
                    out_item_next.frame_overflow = ovf_reg;
                    if (last_replay)
                    begin
                        byte_count_next = '0;
                        crc_next        = CRC_INIT;
                        ovf_next        = 1'b0;
                        state_next      = S_LOAD;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // store writes only in loading, reads only in sealing: no same-entry overlap
    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_store[byte_count_reg[ADDR_W-1:0]] <= byte_item.data_byte;
        if (rd_en)
            rd_data_reg <= frame_store[rd_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            ovf_reg        <= 1'b0;
            crc_idx_reg    <= '0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            ovf_reg        <= ovf_next;
            crc_idx_reg    <= crc_idx_next;
            rd_idx_reg     <= rd_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign seal_valid = out_valid_reg;
    assign seal_item  = out_item_reg;

    // a last byte always starts the crc phase
    a_seal_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && byte_item.last_byte) |=> (state_reg == S_CRC))
        else $error("last byte did not start sealing");

    // store fill never passes its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(FRAME_BYTES))
        else $error("byte count beyond store capacity");

    // replay index stays inside the written part of the store
    a_replay_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND) |-> (rd_idx_reg < byte_count_reg))
        else $error("replay index beyond stored bytes");

    // a byte taken while full is not stored but must flag overflow
    a_ovf_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (byte_count_reg == CNT_W'(FRAME_BYTES))) |=>
        (ovf_reg || $past(byte_item.last_byte)))
        else $error("dropped byte did not raise overflow");

endmodule
